// File: rtl/core/traffic_light_sequencer_core_macros.svh
// Assertion macros shared by the traffic light sequencer RTL.
`ifndef TRAFFIC_LIGHT_SEQUENCER_CORE_MACROS_SVH
`define TRAFFIC_LIGHT_SEQUENCER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define TLS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("traffic light sequencer check failed");
// Expression must never be true outside reset.
`define TLS_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("traffic light sequencer forbidden condition");
`else
`define TLS_ASSERT(label, prop)
`define TLS_ASSERT_NEVER(label, expr)
`endif

`endif

// File: rtl/core/tls_pkg.sv
// Types, codes and constants of the traffic light sequencer.
package tls_pkg;

  localparam int ELAPSED_W = 15;
  localparam int LAMP_W    = 14;
  localparam int IND_W     = 10;
  localparam int LOCK_W    = 10;
  localparam int WIN_W     = 8;
  localparam int CMP_W     = 16;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // Mode codes.
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ONE = 2'd1;
  localparam logic [1:0] MODE_TWO = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WINDOW_HALF     = 2'd0;
  localparam logic [1:0] REG_LOCKOUT_TICKS   = 2'd1;
  localparam logic [1:0] REG_CYCLE_END       = 2'd2;
  localparam logic [1:0] REG_INDICATOR_TICKS = 2'd3;

  // Register reset values.
  localparam logic [WIN_W-1:0]     RST_WINDOW_HALF     = 8'd50;
  localparam logic [LOCK_W-1:0]    RST_LOCKOUT_TICKS   = 10'd500;
  localparam logic [ELAPSED_W-1:0] RST_CYCLE_END       = 15'd19950;
  localparam logic [IND_W-1:0]     RST_INDICATOR_TICKS = 10'd500;

  // Pattern timing.
  localparam logic [LAMP_W-1:0]    FIRST_LOAD   = 14'd9000;
  localparam logic [LAMP_W-1:0]    GREEN_LOAD   = 14'd7000;
  localparam logic [LAMP_W-1:0]    YELLOW_LOAD  = 14'd1000;
  localparam logic [CMP_W-1:0]     CENTER_Y1    = 16'd6000;
  localparam logic [CMP_W-1:0]     CENTER_Y2    = 16'd8000;
  localparam logic [CMP_W-1:0]     CENTER_G     = 16'd9000;
  localparam logic [CMP_W-1:0]     CENTER_Y3    = 16'd16000;
  localparam logic [CMP_W-1:0]     CENTER_Y4    = 16'd18000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = '1;
  localparam logic [LOCK_W-1:0]    LOCK_MAX     = '1;

  typedef struct packed {
    logic [WIN_W-1:0]     window_half;
    logic [LOCK_W-1:0]    lockout_ticks;
    logic [ELAPSED_W-1:0] cycle_end;
    logic [IND_W-1:0]     indicator_ticks;
  } tls_cfg_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic                 cycle_started;
    logic [ELAPSED_W-1:0] cycle_elapsed;
    logic [LAMP_W-1:0]    red_remaining;
    logic [LAMP_W-1:0]    yellow_remaining;
    logic [LAMP_W-1:0]    green_remaining;
    logic [IND_W-1:0]     indicator_remaining;
    logic [LOCK_W-1:0]    lockout_count;
  } tls_state_t;

  typedef struct packed {
    logic       red_lamp;
    logic       yellow_lamp;
    logic       green_lamp;
    logic       press_indicator;
    logic [1:0] mode_now;
  } tls_result_t;

  typedef struct packed {
    logic press_taken;
    logic cycle_done;
  } tls_stat_t;

endpackage

// File: rtl/core/traffic_light_sequencer_core.sv
// Top level of the traffic light sequencer: request pipeline, state and config port.
//
// Each input request is one millisecond tick carrying the sampled button
// level, and each tick produces exactly one result request with the four lamp
// levels and the mode after the tick. The block takes one tick per clock
// cycle unless the output stalls: a tick is captured in an input register,
// the whole tick update is a single pass of short counter and compare logic,
// and the result is then written into the output register. The input
// register and the output register are decoupled, so a new tick is accepted
// while a finished result still waits for out_ready; the input side stalls
// only when both registers are full and the output is stalled. Lamps follow
// their timers after the tick's countdown and before any reloads of the same
// tick. A button press is taken only once lockout_ticks ticks have passed
// since the previous accepted press (and since reset), and it steps the mode
// off, pattern one, pattern two, off. The four configuration registers sit at
// byte addresses 0, 4, 8 and 12 (window_half, lockout_ticks, cycle_end,
// indicator_ticks) and should be written only while no tick is in flight.
`include "traffic_light_sequencer_core_macros.svh"
module traffic_light_sequencer_core import tls_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              button_low,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              red_lamp,
  output logic              yellow_lamp,
  output logic              green_lamp,
  output logic              press_indicator,
  output logic [1:0]        mode_now
);

  tls_cfg_t    cfg;
  tls_state_t  state_q;
  tls_state_t  state_next;
  tls_result_t step_res;
  tls_result_t result_q;
  tls_stat_t   step_stat;

  logic in_valid_q;
  logic button_q;
  logic out_valid_q;
  logic advance;
  logic step_en;

  tls_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tls_step u_step (
    .state_cur  (state_q),
    .cfg        (cfg),
    .button_low (button_q),
    .state_next (state_next),
    .result     (step_res),
    .stat       (step_stat)
  );

  // The output register moves whenever it is empty or being drained.
  assign advance  = !out_valid_q || out_ready;
  assign step_en  = in_valid_q && advance;
  assign in_ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      button_q <= button_low;
    end
  end

  // Sequencer state is committed once per tick, as the tick leaves the
  // input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= '0;
    end else if (step_en) begin
      state_q <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result_q <= step_res;
    end
  end

  assign out_valid       = out_valid_q;
  assign red_lamp        = result_q.red_lamp;
  assign yellow_lamp     = result_q.yellow_lamp;
  assign green_lamp      = result_q.green_lamp;
  assign press_indicator = result_q.press_indicator;
  assign mode_now        = result_q.mode_now;

  // State only moves when a tick is processed.
  `TLS_ASSERT(a_state_hold, !step_en |=> $stable(state_q))
  // An accepted press restarts the lockout count.
  `TLS_ASSERT(a_press_lockout,
              step_en && step_stat.press_taken |=> state_q.lockout_count == '0)
  // Dropping back to off always leaves the three lamp timers cleared.
  `TLS_ASSERT(a_off_clears,
              step_en && state_q.mode != MODE_OFF && state_next.mode == MODE_OFF |=>
              state_q.red_remaining == '0 && state_q.yellow_remaining == '0 &&
              state_q.green_remaining == '0)
  // Passing the cycle end always leaves the block in off.
  `TLS_ASSERT(a_done_off, step_en && step_stat.cycle_done |=> state_q.mode == MODE_OFF)
  // A running cycle implies an active pattern.
  `TLS_ASSERT_NEVER(a_started_off, state_q.cycle_started && state_q.mode == MODE_OFF)
  // The input side stalls only when both registers are occupied.
  `TLS_ASSERT(a_stall_cause, !in_ready |-> in_valid_q && out_valid_q && !out_ready)

endmodule

// File: rtl/core/tls_regs.sv
// APB-style configuration registers of the traffic light sequencer.
module tls_regs import tls_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output tls_cfg_t          cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_half     <= RST_WINDOW_HALF;
      cfg.lockout_ticks   <= RST_LOCKOUT_TICKS;
      cfg.cycle_end       <= RST_CYCLE_END;
      cfg.indicator_ticks <= RST_INDICATOR_TICKS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW_HALF:     cfg.window_half     <= pwdata[WIN_W-1:0];
        REG_LOCKOUT_TICKS:   cfg.lockout_ticks   <= pwdata[LOCK_W-1:0];
        REG_CYCLE_END:       cfg.cycle_end       <= pwdata[ELAPSED_W-1:0];
        REG_INDICATOR_TICKS: cfg.indicator_ticks <= pwdata[IND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_HALF:     prdata = {{(DATA_W-WIN_W){1'b0}}, cfg.window_half};
      REG_LOCKOUT_TICKS:   prdata = {{(DATA_W-LOCK_W){1'b0}}, cfg.lockout_ticks};
      REG_CYCLE_END:       prdata = {{(DATA_W-ELAPSED_W){1'b0}}, cfg.cycle_end};
      REG_INDICATOR_TICKS: prdata = {{(DATA_W-IND_W){1'b0}}, cfg.indicator_ticks};
      default:             prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/tls_step.sv
// Next-state and lamp logic for one tick of the traffic light sequencer.
module tls_step import tls_pkg::*; (
  input  tls_state_t  state_cur,
  input  tls_cfg_t    cfg,
  input  logic        button_low,
  output tls_state_t  state_next,
  output tls_result_t result,
  output tls_stat_t   stat
);

  // True when elapsed lies within center +/- window_half.
  function automatic logic in_window(input logic [ELAPSED_W-1:0] el,
                                     input logic [WIN_W-1:0]     wh,
                                     input logic [CMP_W-1:0]     center);
    logic [CMP_W-1:0] el_w;
    logic [CMP_W-1:0] wh_w;
    el_w = {{(CMP_W-ELAPSED_W){1'b0}}, el};
    wh_w = {{(CMP_W-WIN_W){1'b0}}, wh};
    return (el_w + wh_w >= center) && (el_w <= center + wh_w);
  endfunction

  function automatic logic [LAMP_W-1:0] dec_lamp(input logic [LAMP_W-1:0] v);
    return (v != '0) ? v - 1'b1 : v;
  endfunction

  tls_state_t s;
  logic [1:0] mode_adv;
  logic       win_yellow;
  logic       win_green;

  always_comb begin
    s = state_cur;
    stat = '0;

    // Timers count down first; the lamps show the counted-down values.
    s.red_remaining    = dec_lamp(state_cur.red_remaining);
    s.yellow_remaining = dec_lamp(state_cur.yellow_remaining);
    s.green_remaining  = dec_lamp(state_cur.green_remaining);
    s.indicator_remaining = (state_cur.indicator_remaining != '0) ?
                            state_cur.indicator_remaining - 1'b1 : '0;

    result.red_lamp        = (s.red_remaining != '0);
    result.yellow_lamp     = (s.yellow_remaining != '0);
    result.green_lamp      = (s.green_remaining != '0);
    result.press_indicator = (s.indicator_remaining != '0);

    if (s.lockout_count != LOCK_MAX) begin
      s.lockout_count = s.lockout_count + 1'b1;
    end

    case (state_cur.mode)
      MODE_OFF: mode_adv = MODE_ONE;
      MODE_ONE: mode_adv = MODE_TWO;
      default:  mode_adv = MODE_OFF;
    endcase

    // An accepted press steps the mode and restarts the pattern.
    if (button_low && (s.lockout_count >= cfg.lockout_ticks)) begin
      stat.press_taken      = 1'b1;
      s.lockout_count       = '0;
      s.indicator_remaining = cfg.indicator_ticks;
      s.mode                = mode_adv;
      s.cycle_started       = 1'b0;
      s.cycle_elapsed       = '0;
      s.red_remaining       = '0;
      s.yellow_remaining    = '0;
      s.green_remaining     = '0;
    end

    win_yellow = 1'b0;
    win_green  = 1'b0;
    if (s.mode != MODE_OFF) begin
      if (!s.cycle_started) begin
        s.cycle_started = 1'b1;
        s.cycle_elapsed = '0;
        if (s.mode == MODE_ONE) begin
          s.red_remaining = FIRST_LOAD;
        end else begin
          s.green_remaining = FIRST_LOAD;
        end
      end else if (s.cycle_elapsed != ELAPSED_MAX) begin
        s.cycle_elapsed = s.cycle_elapsed + 1'b1;
      end

      win_yellow = in_window(s.cycle_elapsed, cfg.window_half, CENTER_Y1) ||
                   in_window(s.cycle_elapsed, cfg.window_half, CENTER_Y2) ||
                   in_window(s.cycle_elapsed, cfg.window_half, CENTER_Y3) ||
                   in_window(s.cycle_elapsed, cfg.window_half, CENTER_Y4);
      win_green  = in_window(s.cycle_elapsed, cfg.window_half, CENTER_G);

      // The early yellow windows take priority over the green window.
      if (in_window(s.cycle_elapsed, cfg.window_half, CENTER_Y1) ||
          in_window(s.cycle_elapsed, cfg.window_half, CENTER_Y2)) begin
        s.yellow_remaining = YELLOW_LOAD;
      end else if (win_green) begin
        s.green_remaining = GREEN_LOAD;
      end else if (win_yellow) begin
        s.yellow_remaining = YELLOW_LOAD;
      end

      if (s.cycle_elapsed > cfg.cycle_end) begin
        stat.cycle_done    = 1'b1;
        s.mode             = MODE_OFF;
        s.cycle_started    = 1'b0;
        s.cycle_elapsed    = '0;
        s.red_remaining    = '0;
        s.yellow_remaining = '0;
        s.green_remaining  = '0;
      end
    end

    result.mode_now = s.mode;
    state_next = s;
  end

endmodule
